// ===== sv/frame_timing_state_tracker_top_assert.svh =====
// Assertion macros for the frame timing state tracker.
`ifndef FRAME_TIMING_STATE_TRACKER_TOP_ASSERT_SVH
`define FRAME_TIMING_STATE_TRACKER_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define FTST_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define FTST_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define FTST_ASSERT(label, clk, rst_n, prop)
`define FTST_ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

// ===== sv/ftst_pkg.sv =====
// Shared types and constants for the frame timing state tracker.
package ftst_pkg;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [1:0] {
    ACT_ENTRY   = 2'd0,
    ACT_PRES_V1 = 2'd1,
    ACT_PRES_V2 = 2'd2,
    ACT_ROW     = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    SRC_CPU = 2'd0,
    SRC_APP = 2'd1,
    SRC_PCL = 2'd2
  } source_e;

  typedef enum logic [1:0] {
    RSRC_NONE = 2'd0,
    RSRC_CPU  = 2'd1,
    RSRC_APP  = 2'd2,
    RSRC_PCL  = 2'd3
  } rsrc_e;

  // Classified request handed from front to back.
  typedef struct packed {
    action_e     action;
    logic        app_type;
    logic        presented;
    logic [63:0] screen_time;
    logic [63:0] app_sim;
    logic [63:0] pcl_sim;
    logic [63:0] cpu_end;
    logic [63:0] flip;
    rsrc_e       rsrc;
    logic [63:0] rsim;
    logic [63:0] rfirst;
  } req_t;

  typedef struct packed {
    source_e     src;
    logic [63:0] disp_screen;
    logic [63:0] disp_flip;
    logic [63:0] app_screen;
    logic [63:0] disp_sim;
    logic [63:0] first_sim;
    logic [63:0] last_sim;
  } res_t;
endpackage

// ===== sv/ftst_front.sv =====
// Front end: accepts requests, classifies them and forms the CPU end time.
module ftst_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 stall_o,
  input  logic [1:0]           action_i,
  input  logic [2:0]           frame_type_i,
  input  logic [63:0]          screen_time_i,
  input  logic                 presented_i,
  input  logic [63:0]          app_sim_start_i,
  input  logic [63:0]          pcl_sim_start_i,
  input  logic [63:0]          present_start_i,
  input  logic [63:0]          time_in_present_i,
  input  logic [63:0]          flip_delay_i,
  input  logic [1:0]           resolved_source_i,
  input  logic [63:0]          resolved_sim_start_i,
  input  logic [63:0]          row_first_sim_start_i,
  output logic                 req_valid_o,
  input  logic                 req_stall_i,
  output ftst_pkg::req_t       req_o
);
  import ftst_pkg::*;

  logic valid_q, valid_d;
  req_t req_q, req_d;

  assign stall_o = valid_q && req_stall_i;
  assign req_valid_o = valid_q;
  assign req_o = req_q;

  always_comb begin
    req_d.action      = action_e'(action_i);
    req_d.app_type    = (frame_type_i == 3'd0) || (frame_type_i == 3'd1);
    req_d.presented   = presented_i;
    req_d.screen_time = screen_time_i;
    req_d.app_sim     = app_sim_start_i;
    req_d.pcl_sim     = pcl_sim_start_i;
    req_d.cpu_end     = present_start_i + time_in_present_i;
    req_d.flip        = flip_delay_i;
    req_d.rsrc        = rsrc_e'(resolved_source_i);
    req_d.rsim        = resolved_sim_start_i;
    req_d.rfirst      = row_first_sim_start_i;
    valid_d = valid_q && req_stall_i;
    if (valid_i && !stall_o) valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && !stall_o) begin
      req_q <= req_d;
    end
  end
endmodule

// ===== sv/ftst_queue.sv =====
// Short request queue between front and back.
module ftst_queue #(
  parameter int unsigned Depth = ftst_pkg::QueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  ftst_pkg::req_t in_req_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output ftst_pkg::req_t out_req_o
);
  import ftst_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  req_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0] cnt_q, cnt_d;
  logic push, pop;

  assign in_stall_o  = (cnt_q == (PtrW+1)'(Depth));
  assign out_valid_o = (cnt_q != '0);
  assign out_req_o   = mem_q[rd_q];
  assign push = in_valid_i && !in_stall_o;
  assign pop  = out_valid_o && !out_stall_i;

  always_comb begin
    wr_d = wr_q;
    rd_d = rd_q;
    if (push) wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    if (pop)  rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    cnt_d = cnt_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= in_req_i;
    end
  end
endmodule

// ===== sv/ftst_back.sv =====
// Back end: updates the tracking state and registers one result per present or row.
module ftst_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_stall_o,
  input  ftst_pkg::req_t req_i,
  output logic           valid_o,
  input  logic           stall_i,
  output ftst_pkg::res_t res_o
);
  import ftst_pkg::*;

  source_e     src_q, src_d;
  logic [63:0] dscr_q, dscr_d, dflip_q, dflip_d, ascr_q, ascr_d;
  logic [63:0] dsim_q, dsim_d, first_q, first_d, lsim_q, lsim_d;
  logic        apv_q, apv_d;
  logic [63:0] cpue_q, cpue_d;
  logic        eseen_q, eseen_d, eapp_q, eapp_d, afound_q, afound_d;
  logic [63:0] etime_q, etime_d, atime_q, atime_d;
  logic        ovalid_q;
  res_t        res_q, res_d;
  logic        take, do_src, set_ap, clr;
  logic [63:0] src_scr;

  assign req_stall_o = ovalid_q && stall_i;
  assign take = req_valid_i && !req_stall_o;
  assign valid_o = ovalid_q;
  assign res_o = res_q;

  always_comb begin
    src_d = src_q; dscr_d = dscr_q; dflip_d = dflip_q; ascr_d = ascr_q;
    dsim_d = dsim_q; first_d = first_q; lsim_d = lsim_q;
    apv_d = apv_q; cpue_d = cpue_q;
    eseen_d = eseen_q; eapp_d = eapp_q; etime_d = etime_q;
    afound_d = afound_q; atime_d = atime_q;
    do_src = 1'b0; set_ap = 1'b0; clr = 1'b0;
    src_scr = etime_q;
    case (req_i.action)
      ACT_ENTRY: begin
        eseen_d = 1'b1;
        eapp_d = req_i.app_type;
        etime_d = req_i.screen_time;
        if (req_i.app_type && !afound_q) begin
          afound_d = 1'b1;
          atime_d = req_i.screen_time;
        end
      end
      ACT_PRES_V1: begin
        clr = 1'b1;
        if (req_i.presented) begin
          do_src = eseen_q && eapp_q;
          dscr_d = eseen_q ? etime_q : '0;
          dflip_d = eseen_q ? req_i.flip : '0;
        end
        set_ap = !eseen_q || eapp_q;
      end
      ACT_PRES_V2: begin
        clr = 1'b1;
        src_scr = atime_q;
        if (req_i.presented && eseen_q) begin
          dscr_d = etime_q;
          dflip_d = req_i.flip;
          do_src = afound_q;
          set_ap = afound_q;
        end else begin
          set_ap = !eseen_q || afound_q;
        end
      end
      ACT_ROW: begin
        if (req_i.presented) begin
          dscr_d = req_i.screen_time;
          dflip_d = req_i.flip;
          if (req_i.app_type) begin
            ascr_d = req_i.screen_time;
            if (req_i.rsrc != RSRC_NONE) begin
              src_d = source_e'(req_i.rsrc - 2'd1);
              dsim_d = req_i.rsim;
              if (req_i.rfirst != '0) first_d = req_i.rfirst;
              else if (first_q == '0) first_d = req_i.rsim;
            end
          end
        end
        set_ap = req_i.app_type;
      end
      default: ;
    endcase
    // Source update for a displayed app frame; uses pre-update app state.
    if (do_src) begin
      case (src_q)
        SRC_APP: begin
          if (req_i.app_sim != '0) begin
            dsim_d = req_i.app_sim;
            if (first_q == '0) first_d = req_i.app_sim;
            ascr_d = src_scr;
          end
        end
        SRC_PCL: begin
          if (req_i.app_sim != '0) begin
            src_d = SRC_APP; first_d = req_i.app_sim;
            dsim_d = req_i.app_sim; ascr_d = src_scr;
          end else if (req_i.pcl_sim != '0) begin
            dsim_d = req_i.pcl_sim;
            if (first_q == '0) first_d = req_i.pcl_sim;
            ascr_d = src_scr;
          end
        end
        default: begin
          ascr_d = src_scr;
          if (req_i.app_sim != '0) begin
            src_d = SRC_APP; first_d = req_i.app_sim; dsim_d = req_i.app_sim;
          end else if (req_i.pcl_sim != '0) begin
            src_d = SRC_PCL; first_d = req_i.pcl_sim; dsim_d = req_i.pcl_sim;
          end else if (apv_q) begin
            dsim_d = cpue_q;
          end
        end
      endcase
    end
    if (set_ap) begin
      apv_d = 1'b1;
      cpue_d = req_i.cpu_end;
    end
    if (clr) begin
      eseen_d = 1'b0; eapp_d = 1'b0; etime_d = '0; afound_d = 1'b0; atime_d = '0;
    end
    if (req_i.action != ACT_ENTRY) begin
      if (req_i.pcl_sim != '0) lsim_d = req_i.pcl_sim;
      else if (req_i.app_sim != '0) lsim_d = req_i.app_sim;
    end
    res_d.src = src_d;
    res_d.disp_screen = dscr_d;
    res_d.disp_flip = dflip_d;
    res_d.app_screen = ascr_d;
    res_d.disp_sim = dsim_d;
    res_d.first_sim = first_d;
    res_d.last_sim = lsim_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_q <= SRC_CPU; dscr_q <= '0; dflip_q <= '0; ascr_q <= '0;
      dsim_q <= '0; first_q <= '0; lsim_q <= '0; apv_q <= 1'b0; cpue_q <= '0;
      eseen_q <= 1'b0; eapp_q <= 1'b0; etime_q <= '0;
      afound_q <= 1'b0; atime_q <= '0; ovalid_q <= 1'b0;
    end else begin
      if (take) begin
        src_q <= src_d; dscr_q <= dscr_d; dflip_q <= dflip_d; ascr_q <= ascr_d;
        dsim_q <= dsim_d; first_q <= first_d; lsim_q <= lsim_d;
        apv_q <= apv_d; cpue_q <= cpue_d;
        eseen_q <= eseen_d; eapp_q <= eapp_d; etime_q <= etime_d;
        afound_q <= afound_d; atime_q <= atime_d;
      end
      if (take && req_i.action != ACT_ENTRY) ovalid_q <= 1'b1;
      else if (!stall_i) ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && req_i.action != ACT_ENTRY) begin
      res_q <= res_d;
    end
  end
endmodule

// ===== sv/frame_timing_state_tracker_top.sv =====
// Top level of the frame timing state tracker.
//  channel | valid   | stall   | payload
//  in      | valid_i | stall_o | action_i .. row_first_sim_start_i
//  out     | valid_o | stall_i | animation_source_o .. out_last_sim_o
// One request per cycle sustained while the output is not stalled; a result follows each accepted
// request through the front register, the queue and the back state update, none for display entries.
// Reset clears all tracking state to zero and the source to cpu start.
// A stall on the output backs up the back end, then the queue, then the input.
module frame_timing_state_tracker_top #(
  parameter int unsigned QueueDepth = ftst_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [1:0]  action_i,
  input  logic [2:0]  frame_type_i,
  input  logic [63:0] screen_time_i,
  input  logic        presented_i,
  input  logic [63:0] app_sim_start_i,
  input  logic [63:0] pcl_sim_start_i,
  input  logic [63:0] present_start_i,
  input  logic [63:0] time_in_present_i,
  input  logic [63:0] flip_delay_i,
  input  logic [1:0]  resolved_source_i,
  input  logic [63:0] resolved_sim_start_i,
  input  logic [63:0] row_first_sim_start_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [1:0]  animation_source_o,
  output logic [63:0] out_last_displayed_screen_o,
  output logic [63:0] out_last_flip_delay_o,
  output logic [63:0] out_last_app_screen_o,
  output logic [63:0] out_last_displayed_sim_o,
  output logic [63:0] out_first_app_sim_o,
  output logic [63:0] out_last_sim_o
);
  import ftst_pkg::*;
`include "frame_timing_state_tracker_top_assert.svh"

  req_t f_req, q_req;
  logic f_valid, f_stall, q_valid, q_stall;
  res_t res;

  ftst_front u_front (
    .clk_i, .rst_ni, .valid_i, .stall_o,
    .action_i, .frame_type_i, .screen_time_i, .presented_i,
    .app_sim_start_i, .pcl_sim_start_i, .present_start_i, .time_in_present_i,
    .flip_delay_i, .resolved_source_i, .resolved_sim_start_i, .row_first_sim_start_i,
    .req_valid_o(f_valid), .req_stall_i(f_stall), .req_o(f_req)
  );

  ftst_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i, .rst_ni,
    .in_valid_i(f_valid), .in_stall_o(f_stall), .in_req_i(f_req),
    .out_valid_o(q_valid), .out_stall_i(q_stall), .out_req_o(q_req)
  );

  ftst_back u_back (
    .clk_i, .rst_ni,
    .req_valid_i(q_valid), .req_stall_o(q_stall), .req_i(q_req),
    .valid_o, .stall_i, .res_o(res)
  );

  assign animation_source_o          = res.src;
  assign out_last_displayed_screen_o = res.disp_screen;
  assign out_last_flip_delay_o       = res.disp_flip;
  assign out_last_app_screen_o       = res.app_screen;
  assign out_last_displayed_sim_o    = res.disp_sim;
  assign out_first_app_sim_o         = res.first_sim;
  assign out_last_sim_o              = res.last_sim;

  `FTST_ASSERT(a_src_range, clk_i, rst_ni, !valid_o || animation_source_o != 2'd3)
  `FTST_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, valid_o && stall_i, valid_o && $stable(res))
  `FTST_ASSERT(a_back_pressure, clk_i, rst_ni, !q_stall || (valid_o && stall_i))
endmodule
